// ----- rtl/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rbd_pkg.sv -----
`default_nettype none

package rbd_pkg;

	// Field widths
	localparam int PIX_W       = 8;
	localparam int CH_N        = 3;
	localparam int COORD_W     = 10;
	localparam int DIM_W       = 11;
	localparam int BSZ_REG_W   = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - CH_N * PIX_W - 2 * COORD_W;

	// Configuration bus
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// Limits and defaults
	localparam int HEIGHT_MAX    = 1024;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_BLOCK = 16;
	localparam int RST_BSZ       = 1;
	localparam int RST_WIDTH     = 1024;
	localparam int RST_HEIGHT    = 1024;

	// Controller to datapath commands
	typedef struct packed {
		logic restart;
		logic accept;
		logic acc;
		logic mul;
		logic load;
	} rbd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic emit;
		logic out_free;
	} rbd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rbd_cfg.sv -----
`default_nettype none

module rbd_cfg #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_BLOCK = rbd_pkg::DEF_MAX_BLOCK
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [rbd_pkg::APB_AW-1:0]           paddr,
	input  wire logic [rbd_pkg::APB_DW-1:0]           pwdata,
	output logic      [rbd_pkg::APB_DW-1:0]           prdata,
	output logic                                      pready,
	output logic                                      cfg_wr,
	output logic      [$clog2(MAX_BLOCK+1)-1:0]       bs,
	output logic      [rbd_pkg::DIM_W-1:0]            img_w,
	output logic      [rbd_pkg::DIM_W-1:0]            img_h,
	output logic                                      fits
);
	import rbd_pkg::*;

	localparam int BLK_W = $clog2(MAX_BLOCK);
	localparam int BS_W  = $clog2(MAX_BLOCK + 1);
	localparam int FK    = DIM_W + BLK_W;
	localparam int FM_W  = FK + 1;

	logic [BSZ_REG_W-1:0] bsz_q;
	logic [DIM_W-1:0]     wid_q;
	logic [DIM_W-1:0]     hgt_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	logic [FM_W-1:0]      rcp [0:MAX_BLOCK];
	logic [DIM_W+FM_W-1:0] qw_full;
	logic [DIM_W+FM_W-1:0] qh_full;
	logic [DIM_W-1:0]     qw_q;
	logic [DIM_W-1:0]     qh_q;
	logic [DIM_W+BS_W-1:0] bw;
	logic [DIM_W+BS_W-1:0] bh;
	logic                 fits_q;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg_wr = wr_en && ((idx == REG_BLOCK_SIZE) || (idx == REG_IMAGE_WIDTH)
		|| (idx == REG_IMAGE_HEIGHT));

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q <= BSZ_REG_W'(RST_BSZ);
			wid_q <= DIM_W'(RST_WIDTH);
			hgt_q <= DIM_W'(RST_HEIGHT);
		end else if (wr_en) begin
			unique case (idx)
				REG_BLOCK_SIZE:   bsz_q <= pwdata[BSZ_REG_W-1:0];
				REG_IMAGE_WIDTH:  wid_q <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: hgt_q <= pwdata[DIM_W-1:0];
				default:          ;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (idx)
			REG_BLOCK_SIZE:   prdata = APB_DW'(bsz_q);
			REG_IMAGE_WIDTH:  prdata = APB_DW'(wid_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(hgt_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp to the supported ranges; zero behaves as one
	always_comb begin
		if (bsz_q == '0)
			bs = BS_W'(1);
		else if (int'(bsz_q) > MAX_BLOCK)
			bs = BS_W'(MAX_BLOCK);
		else
			bs = BS_W'(bsz_q);

		if (wid_q == '0)
			img_w = DIM_W'(1);
		else if (int'(wid_q) > MAX_WIDTH)
			img_w = DIM_W'(MAX_WIDTH);
		else
			img_w = wid_q;

		if (hgt_q == '0)
			img_h = DIM_W'(1);
		else if (int'(hgt_q) > HEIGHT_MAX)
			img_h = DIM_W'(HEIGHT_MAX);
		else
			img_h = hgt_q;
	end

	// Reciprocals of the block size, exact floor for any dimension value
	for (genvar i = 0; i <= MAX_BLOCK; i++) begin : g_rcp
		localparam longint unsigned D = (i == 0) ? 1 : i;
		localparam longint unsigned M = ((64'd1 << FK) + D - 64'd1) / D;
		assign rcp[i] = FM_W'(M);
	end

	// Block-fit check: quotient first, then multiply back and compare
	assign qw_full = img_w * rcp[bs];
	assign qh_full = img_h * rcp[bs];
	assign bw      = qw_q * bs;
	assign bh      = qh_q * bs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q   <= '0;
			qh_q   <= '0;
			fits_q <= 1'b0;
		end else begin
			qw_q   <= qw_full[FK +: DIM_W];
			qh_q   <= qh_full[FK +: DIM_W];
			fits_q <= (bw == (DIM_W+BS_W)'(img_w)) && (bh == (DIM_W+BS_W)'(img_h));
		end
	end

	assign fits = fits_q;

endmodule

`default_nettype wire

// ----- rtl/rbd_ctrl.sv -----
`default_nettype none

module rbd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rbd_pkg::rbd_stat_t stat,
	output rbd_pkg::rbd_cmd_t       cmd
);
	import rbd_pkg::*;

	localparam logic [2:0] ST_HOLD = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       hold_q;
	logic       hold_nx;

	// Sequencing: hold, read, accumulate, then for a block-closing pixel multiply and load output
	always_comb begin
		state_nx = state_q;
		hold_nx  = hold_q;
		cmd      = '0;
		in_ready = 1'b0;
		if (cfg_wr) begin
			state_nx = ST_HOLD;
			hold_nx  = 1'b1;
		end else begin
			unique case (state_q)
				ST_HOLD: begin
					cmd.restart = 1'b1;
					if (hold_q)
						hold_nx = 1'b0;
					else
						state_nx = ST_IDLE;
				end
				ST_IDLE: begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_nx   = ST_ACC;
					end
				end
				ST_ACC: begin
					cmd.acc  = 1'b1;
					state_nx = stat.emit ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					cmd.mul  = 1'b1;
					state_nx = ST_OUT;
				end
				ST_OUT: begin
					if (stat.out_free) begin
						cmd.load = 1'b1;
						state_nx = ST_IDLE;
					end
				end
				default: state_nx = ST_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HOLD;
			hold_q  <= 1'b1;
		end else begin
			state_q <= state_nx;
			hold_q  <= hold_nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rbd_dp.sv -----
`default_nettype none

module rbd_dp #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_BLOCK = rbd_pkg::DEF_MAX_BLOCK
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire rbd_pkg::rbd_cmd_t                  cmd,
	output rbd_pkg::rbd_stat_t                      stat,
	input  wire logic [$clog2(MAX_BLOCK+1)-1:0]     bs,
	input  wire logic [rbd_pkg::DIM_W-1:0]          img_w,
	input  wire logic [rbd_pkg::DIM_W-1:0]          img_h,
	input  wire logic                               fits,
	input  wire logic [rbd_pkg::IN_TDATA_W-1:0]     pix_data,
	output logic      [rbd_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic                                    out_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready
);
	import rbd_pkg::*;

	localparam int BLK_W  = $clog2(MAX_BLOCK);
	localparam int BS_W   = $clog2(MAX_BLOCK + 1);
	localparam int IDX_W  = $clog2(MAX_WIDTH);
	localparam int SUM_W  = PIX_W + 2 * BLK_W;
	localparam int AK     = SUM_W + 2 * BLK_W;
	localparam int AM_W   = AK + 1;
	localparam int PROD_W = SUM_W + AM_W;

	// Position counters
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [BLK_W-1:0] cib_q;
	logic [BLK_W-1:0] rib_q;
	logic [DIM_W-1:0] ocol_q;
	logic [DIM_W-1:0] orow_q;
	logic             row_end;
	logic             img_end;
	logic             bcol_end;
	logic             brow_end;

	// Line store of per-column channel sums
	logic [CH_N-1:0][SUM_W-1:0] line_mem [MAX_WIDTH];
	logic [IDX_W-1:0]           rd_idx;
	logic [IDX_W-1:0]           wr_idx;

	// Pipeline
	logic [CH_N-1:0][PIX_W-1:0]  pix_s1;
	logic [CH_N-1:0][SUM_W-1:0]  rd_s1;
	logic [DIM_W-1:0]            ocol_s1;
	logic [DIM_W-1:0]            orow_s1;
	logic                        first_s1;
	logic                        eoi_s1;
	logic                        emit_s1;
	logic [CH_N-1:0][SUM_W-1:0]  sum_nx;
	logic [CH_N-1:0][SUM_W-1:0]  sum_s2;
	logic [DIM_W-1:0]            ocol_s2;
	logic [DIM_W-1:0]            orow_s2;
	logic                        eoi_s2;
	logic [CH_N-1:0][PROD_W-1:0] prod_s3;
	logic [CH_N-1:0][PIX_W-1:0]  avg;
	logic [AM_W-1:0]             rcp [0:MAX_BLOCK];

	// Output register
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_last_q;
	logic                   out_valid_q;

	// Position flags for the pixel at the input
	assign row_end  = (col_q == img_w - DIM_W'(1));
	assign img_end  = row_end && (row_q == img_h - DIM_W'(1));
	assign bcol_end = (BS_W'(cib_q) == bs - BS_W'(1));
	assign brow_end = (BS_W'(rib_q) == bs - BS_W'(1));

	// Raster walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cib_q  <= '0;
			rib_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cmd.restart) begin
			col_q  <= '0;
			row_q  <= '0;
			cib_q  <= '0;
			rib_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cmd.accept) begin
			if (row_end) begin
				col_q  <= '0;
				cib_q  <= '0;
				ocol_q <= '0;
				if (img_end) begin
					row_q  <= '0;
					rib_q  <= '0;
					orow_q <= '0;
				end else begin
					row_q  <= row_q + DIM_W'(1);
					rib_q  <= brow_end ? '0 : rib_q + BLK_W'(1);
					orow_q <= brow_end ? orow_q + DIM_W'(1) : orow_q;
				end
			end else begin
				col_q  <= col_q + DIM_W'(1);
				cib_q  <= bcol_end ? '0 : cib_q + BLK_W'(1);
				ocol_q <= bcol_end ? ocol_q + DIM_W'(1) : ocol_q;
			end
		end
	end

	// Accumulate: first pixel of a block overwrites its entry
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			sum_nx[c] = first_s1 ? SUM_W'(pix_s1[c]) : rd_s1[c] + SUM_W'(pix_s1[c]);
		end
	end

	assign rd_idx = IDX_W'(ocol_q);
	assign wr_idx = IDX_W'(ocol_s1);

	// Line store: read on accept, write back in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.accept)
			rd_s1 <= line_mem[rd_idx];
		if (cmd.acc)
			line_mem[wr_idx] <= sum_nx;
	end

	// Reciprocals of the block area, exact floor for any sum
	for (genvar i = 0; i <= MAX_BLOCK; i++) begin : g_rcp
		localparam longint unsigned D = (i == 0) ? 1 : i * i;
		localparam longint unsigned M = ((64'd1 << AK) + D - 64'd1) / D;
		assign rcp[i] = AM_W'(M);
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_s1   <= pix_data;
			ocol_s1  <= ocol_q;
			orow_s1  <= orow_q;
			first_s1 <= (cib_q == '0) && (rib_q == '0);
			eoi_s1   <= img_end;
			emit_s1  <= fits && brow_end && bcol_end;
		end
		if (cmd.acc) begin
			sum_s2  <= sum_nx;
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
			eoi_s2  <= eoi_s1;
		end
		if (cmd.mul) begin
			for (int c = 0; c < CH_N; c++) begin
				prod_s3[c] <= sum_s2[c] * rcp[bs];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			avg[c] = prod_s3[c][AK +: PIX_W];
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, COORD_W'(orow_s2), COORD_W'(ocol_s2), avg};
			out_last_q <= eoi_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_data      = out_data_q;
	assign out_last      = out_last_q;
	assign out_valid     = out_valid_q;
	assign stat.emit     = emit_s1;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ----- rtl/rgb_box_downsampler_unit.sv -----
// Channel  Dir  Handshake             Word
// s_axis   in   tvalid/tready         tdata[23:0]: red_in, green_in, blue_in
// m_axis   out  tvalid/tready/tlast   tdata[47:0]: averages, out_col, out_row; tlast: end
// apb      in   psel/penable/pready   0x0 block_size, 0x4 image_width, 0x8 image_height
//
// A pixel is taken with a line-store read, then accumulated and written back.
// A block-closing pixel then goes on to the reciprocal multiply and the output load.
// The output register lets the next pixel in while an averaged word waits on m_axis_tready.
// After reset and after each register write, input is held off while the
// position counters clear and the block-fit check settles.
// The line store is not cleared; the first pixel of each block overwrites its entry.
`default_nettype none

module rgb_box_downsampler_unit #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_BLOCK = rbd_pkg::DEF_MAX_BLOCK
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	input  wire logic [rbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// red_avg [7:0], green_avg [15:8], blue_avg [23:16], out_col [33:24],
	// out_row [43:34], zeros [47:44]
	output logic      [rbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                    m_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rbd_pkg::APB_AW-1:0]         paddr,
	input  wire logic [rbd_pkg::APB_DW-1:0]         pwdata,
	output logic      [rbd_pkg::APB_DW-1:0]         prdata,
	output logic                                    pready
);
	import rbd_pkg::*;

	localparam int BS_W = $clog2(MAX_BLOCK + 1);

	logic             cfg_wr;
	logic [BS_W-1:0]  bs;
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	logic             fits;
	rbd_cmd_t         cmd;
	rbd_stat_t        stat;

	rbd_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg_wr  (cfg_wr),
		.bs      (bs),
		.img_w   (img_w),
		.img_h   (img_h),
		.fits    (fits)
	);

	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rbd_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.bs        (bs),
		.img_w     (img_w),
		.img_h     (img_h),
		.fits      (fits),
		.pix_data  (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule

`default_nettype wire

// ----- rtl/rbd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module rbd_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [rbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                            m_axis_tlast,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic                            pready,
	input  wire logic [rbd_pkg::APB_AW-1:0]      paddr
);
	import rbd_pkg::*;

	logic in_acc;
	logic reg_wr;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign reg_wr = psel && penable && pwrite && pready
		&& ((paddr[APB_AW-1:2] == REG_BLOCK_SIZE) || (paddr[APB_AW-1:2] == REG_IMAGE_WIDTH)
		|| (paddr[APB_AW-1:2] == REG_IMAGE_HEIGHT));

	// A stalled output word holds
	`RBD_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

	// Accumulate cycle follows every accepted pixel
	`RBD_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_acc, !s_axis_tready, "pixel taken during accumulate cycle")

	// Register write holds off input while the fit check settles
	`RBD_ASSERT_NXT(a_cfg_hold, clk, arst_n, reg_wr, !s_axis_tready, "input ready right after register write")

	// New output word is loaded only from the output-load cycle
	`RBD_ASSERT_IMP(a_out_from_load, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "output word appeared outside load cycle")

endmodule

bind rgb_box_downsampler_unit rbd_checker u_rbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.pready        (pready),
	.paddr         (paddr)
);

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
	import rbd_pkg::*;

	localparam int LINE_MAX    = 1024;
	localparam int BLOCK_MAX   = 16;
	localparam int SUM_W       = 16;
	localparam int RANDOM_PX   = 1950;
	localparam int SPLIT_A     = 660;
	localparam int SPLIT_B     = 1320;
	localparam int DRAIN_WAIT  = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// one averaged output word, unpacked
	typedef struct packed {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} avg_pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// red_avg, green_avg, blue_avg, out_col, out_row, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	// stimulus and scoreboard
	logic [IN_TDATA_W-1:0] pixel_feed[$];
	avg_pixel_t            avg_due[$];
	int unsigned           px_taken = 0;
	int unsigned           mismatches = 0;
	int unsigned           cycles = 0;
	int unsigned           src_idle_pct;
	int unsigned           sink_idle_pct;
	logic                  hold_req = 1'b0;
	logic                  hold_done = 1'b0;
	int unsigned           hold_left = 0;

	// shadow of the block: line store, position counters, registers
	logic [SUM_W-1:0]      sum_red[LINE_MAX];
	logic [SUM_W-1:0]      sum_green[LINE_MAX];
	logic [SUM_W-1:0]      sum_blue[LINE_MAX];
	int unsigned           col_pos, row_pos, col_in_blk, row_in_blk;
	logic [BSZ_REG_W-1:0]  cfg_block;
	logic [DIM_W-1:0]      cfg_width;
	logic [DIM_W-1:0]      cfg_height;

	rgb_box_downsampler_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void restart_image();
		col_pos = 0;
		row_pos = 0;
		col_in_blk = 0;
		row_in_blk = 0;
	endfunction

	// add one pixel into its column sum; returns 1 when it closes a block of an image the blocks fit
	function automatic bit accumulate_pixel(input logic [IN_TDATA_W-1:0] word,
			output avg_pixel_t avg);
		int unsigned      bs, w, h, oc, area;
		logic [PIX_W-1:0] r, g, b;
		bit               closes;
		bs = clamp_dim(cfg_block, BLOCK_MAX);
		w = clamp_dim(cfg_width, LINE_MAX);
		h = clamp_dim(cfg_height, HEIGHT_MAX);
		{b, g, r} = word;
		oc = col_pos / bs;
		// first pixel of a block overwrites the stale entry
		if (row_in_blk == 0 && col_in_blk == 0) begin
			sum_red[oc] = SUM_W'(r);
			sum_green[oc] = SUM_W'(g);
			sum_blue[oc] = SUM_W'(b);
		end else begin
			sum_red[oc] = sum_red[oc] + r;
			sum_green[oc] = sum_green[oc] + g;
			sum_blue[oc] = sum_blue[oc] + b;
		end
		closes = (w % bs == 0) && (h % bs == 0) && row_in_blk == bs - 1 && col_in_blk == bs - 1;
		avg = '0;
		if (closes) begin
			area = bs * bs;
			avg.red = PIX_W'(sum_red[oc] / area);
			avg.green = PIX_W'(sum_green[oc] / area);
			avg.blue = PIX_W'(sum_blue[oc] / area);
			avg.col = COORD_W'(oc);
			avg.row = COORD_W'(row_pos / bs);
			avg.last = (col_pos == w - 1) && (row_pos == h - 1);
		end
		// raster advance, wrapping at end of line and end of image
		col_in_blk++;
		if (col_in_blk >= bs)
			col_in_blk = 0;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			col_in_blk = 0;
			row_in_blk++;
			if (row_in_blk >= bs)
				row_in_blk = 0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				row_in_blk = 0;
			end
		end
		return closes;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// idle mix: sender light and sink heavy, then swapped, then none
	always_comb begin
		if (px_taken < SPLIT_A) begin
			src_idle_pct = 27;
			sink_idle_pct = 66;
		end else if (px_taken < SPLIT_B) begin
			src_idle_pct = 66;
			sink_idle_pct = 27;
		end else begin
			src_idle_pct = 0;
			sink_idle_pct = 0;
		end
	end

	// pixel source
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pixel_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_axis_tdata <= pixel_feed.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long hold-off of the sink, started once on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result sink
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
	end

	// monitor: check each output word, predict each accepted pixel
	always @(posedge clk) begin
		avg_pixel_t           got, want, pred;
		logic [OUT_PAD_W-1:0] pad;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				{pad, got.row, got.col, got.blue, got.green, got.red} = m_axis_tdata;
				got.last = m_axis_tlast;
				if (pad != '0)
					report_mismatch("tdata pad", pad, 0);
				if (avg_due.size() == 0) begin
					report_mismatch("word with none pending", got.col, 0);
				end else begin
					want = avg_due.pop_front();
					if (got.red != want.red)
						report_mismatch("red_avg", got.red, want.red);
					if (got.green != want.green)
						report_mismatch("green_avg", got.green, want.green);
					if (got.blue != want.blue)
						report_mismatch("blue_avg", got.blue, want.blue);
					if (got.col != want.col)
						report_mismatch("out_col", got.col, want.col);
					if (got.row != want.row)
						report_mismatch("out_row", got.row, want.row);
					if (got.last != want.last)
						report_mismatch("end_of_image", got.last, want.last);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				px_taken <= px_taken + 1;
				if (accumulate_pixel(s_axis_tdata, pred))
					avg_due.push_back(pred);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// block idle: nothing queued, nothing in flight, nothing owed
	task automatic wait_drained();
		while (pixel_feed.size() != 0 || s_axis_tvalid || avg_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		bit known;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		known = 1'b1;
		case (idx)
			REG_BLOCK_SIZE:   cfg_block = data[BSZ_REG_W-1:0];
			REG_IMAGE_WIDTH:  cfg_width = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
			default:          known = 1'b0;
		endcase
		// a write to a real register starts a new image
		if (known)
			restart_image();
	endtask

	task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int unsigned bs, input int unsigned w, input int unsigned h);
		logic [APB_DW-1:0] rd;
		wait_drained();
		apb_write(REG_BLOCK_SIZE, bs);
		apb_write(REG_IMAGE_WIDTH, w);
		apb_write(REG_IMAGE_HEIGHT, h);
		apb_read(REG_BLOCK_SIZE, rd);
		if (rd != cfg_block)
			report_mismatch("block_size readback", rd, cfg_block);
		apb_read(REG_IMAGE_WIDTH, rd);
		if (rd != cfg_width)
			report_mismatch("image_width readback", rd, cfg_width);
		apb_read(REG_IMAGE_HEIGHT, rd);
		if (rd != cfg_height)
			report_mismatch("image_height readback", rd, cfg_height);
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		pixel_feed.push_back({b, g, r});
	endtask

	task automatic push_random(input int unsigned n);
		repeat (n) pixel_feed.push_back(IN_TDATA_W'($urandom));
	endtask

	// stimulus
	initial begin
		int unsigned bs_reg, eb, w_reg, h_reg, img_px, n, sel, random_px;
		for (int i = 0; i < LINE_MAX; i++) begin
			sum_red[i] = '0;
			sum_green[i] = '0;
			sum_blue[i] = '0;
		end
		cfg_block = RST_BSZ;
		cfg_width = RST_WIDTH;
		cfg_height = RST_HEIGHT;
		restart_image();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// 2x2 blocks on a 2x2 image: channel extremes, then wrap into a second image
		configure(2, 2, 2);
		push_pixel(8'hFF, 8'h00, 8'hFF);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'h00, 8'h00);
		repeat (4) push_pixel(8'hFF, 8'hFF, 8'hFF);

		// zero block size, width and height all behave as one
		configure(0, 0, 0);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);

		// width not a multiple of the block: pixels taken, nothing out
		configure(3, 4, 3);
		push_random(6);

		// write to the unused register slot mid-image must not restart it
		configure(2, 4, 2);
		push_random(3);
		wait_drained();
		apb_write(REG_SPARE, '1);
		push_random(5);

		// oversized width clamps to the full line; sink holds off meanwhile
		configure(1, 2047, 1);
		@(posedge clk);
		hold_req <= 1'b1;
		push_random(LINE_MAX + 4);
		random_px = LINE_MAX + 4;

		// random settings, mostly small blocks and small images
		while (random_px < RANDOM_PX) begin
			sel = $urandom_range(9);
			if (sel < 7)
				bs_reg = $urandom_range(1, 4);
			else if (sel < 9)
				bs_reg = $urandom_range(5, 16);
			else
				bs_reg = $urandom_range(1) ? 0 : $urandom_range(17, 31);
			eb = clamp_dim(bs_reg, BLOCK_MAX);
			w_reg = eb * $urandom_range(1, (eb > 4) ? 2 : 5);
			h_reg = eb * $urandom_range(1, (eb > 4) ? 1 : 4);
			sel = $urandom_range(19);
			if (sel == 0)
				w_reg = $urandom_range(1, 4 * eb);
			else if (sel == 1)
				h_reg = $urandom_range(1, 4 * eb);
			else if (sel == 2)
				h_reg = $urandom_range(1) ? 0 : 2047;
			else if (sel == 3 && eb == 1)
				w_reg = 0;
			img_px = clamp_dim(w_reg, LINE_MAX) * clamp_dim(h_reg, HEIGHT_MAX);
			// whole images plus a partial one cut short by the next write; over 400 becomes 100 to 400
			n = $urandom_range(1, 2) * img_px + $urandom_range(0, img_px / 2);
			if (n > 400)
				n = $urandom_range(100, 400);
			configure(bs_reg, w_reg, h_reg);
			push_random(n);
			random_px += n;
		end

		wait_drained();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_cfg.sv
rtl/rbd_ctrl.sv
rtl/rbd_dp.sv
rtl/rgb_box_downsampler_unit.sv
rtl/rbd_checker.sv
sim/testbench.sv
